>>> rtl/core/tshd_pkg.sv
// ----------------------------------------------------------------------------
// tshd_pkg
// Shared types and codes for the touch swipe-and-hold detector.
// ----------------------------------------------------------------------------
package tshd_pkg;

    localparam int THR_W      = 12;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FIELD_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_MS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_HORIZ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_VERT    = 3'd5;

    // reset values of the configuration registers
    localparam logic [THR_W-1:0]  RST_SWIPE_THR   = 12'd400;
    localparam logic [THR_W-1:0]  RST_RELEASE_THR = 12'd200;
    localparam logic [TIME_W-1:0] RST_CONFIRM_MS  = 32'd1000;

    // result phase codes
    localparam logic [FIELD_W-1:0] PHASE_NONE      = 2'd0;
    localparam logic [FIELD_W-1:0] PHASE_HOLDING   = 2'd1;
    localparam logic [FIELD_W-1:0] PHASE_CONFIRMED = 2'd2;

    // direction codes
    localparam logic [FIELD_W-1:0] DIR_LEFT  = 2'd0;
    localparam logic [FIELD_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [FIELD_W-1:0] DIR_UP    = 2'd2;
    localparam logic [FIELD_W-1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic [THR_W-1:0]  swipe_thr;
        logic [THR_W-1:0]  release_thr;
        logic [TIME_W-1:0] confirm_ms;
        logic              swap_axes;
        logic              inv_horiz;
        logic              inv_vert;
    } t_cfg;

    // classified sample handed from front to back
    typedef struct packed {
        logic               move;       // pressed and pen already down
        logic               ge_swipe;   // magnitude reaches swipe threshold
        logic               ge_release; // magnitude reaches release threshold
        logic [FIELD_W-1:0] dir;        // candidate direction
        logic [TIME_W-1:0]  time_ms;
    } t_item;

    typedef struct packed {
        logic active;
        logic confirm_sent;
    } t_back_status;

endpackage

>>> rtl/core/tshd_front.sv
// ----------------------------------------------------------------------------
// tshd_front
// Tracks pen state and anchor, forms the oriented offset and classifies it.
// ----------------------------------------------------------------------------
module tshd_front import tshd_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic              i_pressed,
    input  logic [11:0]       i_sample_x,
    input  logic [11:0]       i_sample_y,
    input  logic [TIME_W-1:0] i_time_ms,
    output t_item             o_item
);

    localparam int DW = COORD_BITS + 1;
    localparam int CW = (DW > THR_W) ? DW : THR_W;

    logic                  r_pen_down;
    logic [COORD_BITS-1:0] r_anchor_x;
    logic [COORD_BITS-1:0] r_anchor_y;

    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic signed [DW-1:0]  rdx;
    logic signed [DW-1:0]  rdy;
    logic signed [DW-1:0]  sdx;
    logic signed [DW-1:0]  sdy;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic [DW-1:0]         adx;
    logic [DW-1:0]         ady;
    logic [DW-1:0]         mag;
    logic                  dx_pos;
    logic                  dy_pos;

    assign x = COORD_BITS'(i_sample_x);
    assign y = COORD_BITS'(i_sample_y);

    assign rdx = $signed({1'b0, x}) - $signed({1'b0, r_anchor_x});
    assign rdy = $signed({1'b0, y}) - $signed({1'b0, r_anchor_y});
    assign sdx = i_cfg.swap_axes ? rdy : rdx;
    assign sdy = i_cfg.swap_axes ? rdx : rdy;
    assign dx  = i_cfg.inv_horiz ? -sdx : sdx;
    assign dy  = i_cfg.inv_vert  ? -sdy : sdy;

    assign adx = dx[DW-1] ? $unsigned(-dx) : $unsigned(dx);
    assign ady = dy[DW-1] ? $unsigned(-dy) : $unsigned(dy);
    assign mag = (adx > ady) ? adx : ady;

    assign dx_pos = !dx[DW-1] && (dx != '0);
    assign dy_pos = !dy[DW-1] && (dy != '0);

    always_comb begin
        o_item.move       = i_pressed && r_pen_down;
        o_item.ge_swipe   = CW'(mag) >= CW'(i_cfg.swipe_thr);
        o_item.ge_release = CW'(mag) >= CW'(i_cfg.release_thr);
        o_item.time_ms    = i_time_ms;
        // ties go to the vertical axis
        if (adx > ady) begin
            o_item.dir = dx_pos ? DIR_RIGHT : DIR_LEFT;
        end else begin
            o_item.dir = dy_pos ? DIR_DOWN : DIR_UP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_down <= 1'b0;
        end else if (i_accept) begin
            r_pen_down <= i_pressed;
        end
    end

    // latch the anchor on a fresh touch
    always_ff @(posedge i_clk) begin
        if (i_accept && i_pressed && !r_pen_down) begin
            r_anchor_x <= x;
            r_anchor_y <= y;
        end
    end

endmodule

>>> rtl/core/tshd_queue.sv
// ----------------------------------------------------------------------------
// tshd_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module tshd_queue import tshd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    t_item              r_mem [DEPTH];
    logic [PW-1:0]      r_wr_ptr;
    logic [PW-1:0]      r_rd_ptr;
    logic [PW:0]        r_count;
    logic [PW:0]        n_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> rtl/core/tshd_back.sv
// ----------------------------------------------------------------------------
// tshd_back
// Gesture state and result register: starts, times, confirms and drops holds.
// ----------------------------------------------------------------------------
module tshd_back import tshd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_item              i_item,
    output logic               o_pop,
    output t_back_status       o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FIELD_W-1:0] o_phase,
    output logic [FIELD_W-1:0] o_direction,
    output logic [TIME_W-1:0]  o_held_ms
);

    logic               r_active;
    logic               r_confirm_sent;
    logic [FIELD_W-1:0] r_dir;
    logic [TIME_W-1:0]  r_start_ms;

    logic               r_out_valid;
    logic [FIELD_W-1:0] r_phase;
    logic [FIELD_W-1:0] r_out_dir;
    logic [TIME_W-1:0]  r_held;

    logic               n_active;
    logic               n_confirm_sent;
    logic               n_start;
    logic [FIELD_W-1:0] n_phase;
    logic [FIELD_W-1:0] n_out_dir;
    logic [TIME_W-1:0]  n_held;
    logic [TIME_W-1:0]  held;

    // advance when the result register is free or being drained
    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);
    assign held  = i_item.time_ms - r_start_ms;

    always_comb begin
        n_active       = r_active;
        n_confirm_sent = r_confirm_sent;
        n_start        = 1'b0;
        n_phase        = PHASE_NONE;
        n_out_dir      = DIR_LEFT;
        n_held         = '0;
        priority if (!i_item.move) begin
            n_active = 1'b0;
        end else if (!r_active) begin
            if (i_item.ge_swipe) begin
                n_active       = 1'b1;
                n_confirm_sent = 1'b0;
                n_start        = 1'b1;
                n_phase        = PHASE_HOLDING;
                n_out_dir      = i_item.dir;
            end
        end else if (!i_item.ge_release) begin
            n_active = 1'b0;
        end else begin
            n_out_dir = r_dir;
            n_held    = held;
            if (!r_confirm_sent && (held >= i_cfg.confirm_ms)) begin
                n_confirm_sent = 1'b1;
                n_phase        = PHASE_CONFIRMED;
            end else begin
                n_phase = PHASE_HOLDING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_confirm_sent <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active       <= n_active;
                r_confirm_sent <= n_confirm_sent;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_phase   <= n_phase;
            r_out_dir <= n_out_dir;
            r_held    <= n_held;
            if (n_start) begin
                r_dir      <= i_item.dir;
                r_start_ms <= i_item.time_ms;
            end
        end
    end

    assign o_status.active       = r_active;
    assign o_status.confirm_sent = r_confirm_sent;
    assign o_out_valid           = r_out_valid;
    assign o_phase               = r_phase;
    assign o_direction           = r_out_dir;
    assign o_held_ms             = r_held;

endmodule

>>> rtl/core/touch_swipe_hold_detector.sv
// ----------------------------------------------------------------------------
// touch_swipe_hold_detector
// Swipe-and-hold gesture detection on a stream of touch-panel samples.
//
// Channel   Direction  Handshake                    Beat
// in        sink       i_in_valid / o_in_stall      pressed, sample x/y, time_ms
// out       source     o_out_valid / i_out_stall    phase, direction, held_ms
// cfg       sink       i_cfg_valid / o_cfg_ready    register index, write data
//
// One beat per cycle in and out while neither side stalls; every input beat gives one result beat.
// An input beat passes through the front-to-back queue and then through the
// result register of the back part.
// o_in_stall rises when the two-entry queue is full. o_cfg_ready is always high.
// Synchronous active-low reset clears pen, gesture and queue state and loads
// the register defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
module touch_swipe_hold_detector import tshd_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_pressed,
    input  logic [11:0]           i_sample_x,
    input  logic [11:0]           i_sample_y,
    input  logic [TIME_W-1:0]     i_time_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FIELD_W-1:0]    o_phase,
    output logic [FIELD_W-1:0]    o_direction,
    output logic [TIME_W-1:0]     o_held_ms,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg         r_cfg;
    t_item        front_item;
    t_item        q_item;
    t_back_status back_status;
    logic         in_accept;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swipe_thr   <= RST_SWIPE_THR;
            r_cfg.release_thr <= RST_RELEASE_THR;
            r_cfg.confirm_ms  <= RST_CONFIRM_MS;
            r_cfg.swap_axes   <= 1'b0;
            r_cfg.inv_horiz   <= 1'b0;
            r_cfg.inv_vert    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SWIPE_THR:   r_cfg.swipe_thr   <= i_cfg_data[THR_W-1:0];
                CFG_RELEASE_THR: r_cfg.release_thr <= i_cfg_data[THR_W-1:0];
                CFG_CONFIRM_MS:  r_cfg.confirm_ms  <= i_cfg_data[TIME_W-1:0];
                CFG_SWAP_AXES:   r_cfg.swap_axes   <= i_cfg_data[0];
                CFG_INV_HORIZ:   r_cfg.inv_horiz   <= i_cfg_data[0];
                CFG_INV_VERT:    r_cfg.inv_vert    <= i_cfg_data[0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    tshd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (in_accept),
        .i_pressed  (i_pressed),
        .i_sample_x (i_sample_x),
        .i_sample_y (i_sample_y),
        .i_time_ms  (i_time_ms),
        .o_item     (front_item)
    );

    tshd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    tshd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_status    (back_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_phase     (o_phase),
        .o_direction (o_direction),
        .o_held_ms   (o_held_ms)
    );

    // a result with no gesture carries zero direction and time
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_phase == PHASE_NONE)) |->
            ((o_direction == DIR_LEFT) && (o_held_ms == '0)))
        else $error("none result with nonzero direction or time");

    // a hold starts together with a holding beat at zero elapsed time
    a_hold_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(back_status.active) |->
            (o_out_valid && (o_phase == PHASE_HOLDING) && (o_held_ms == '0)))
        else $error("hold started without a holding beat");

    // confirmation is marked exactly when a confirmed beat is loaded
    a_confirm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(back_status.confirm_sent) |->
            (o_out_valid && (o_phase == PHASE_CONFIRMED)))
        else $error("confirm flag set without a confirmed beat");

endmodule
